FILE: rtl/obplf_pkg.sv
// ----------------------------------------------------------------------------
// obplf_pkg
// Types and codes shared by the order book price level FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package obplf_pkg;

    typedef struct packed {
        logic               action;
        logic signed [31:0] price;
        logic [23:0]        quantity;
        logic [12:0]        order_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] assigned_id;
        logic [5:0]  level_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADD,
        S_CANCEL,
        S_EMIT
    } t_state;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_CANCEL = 1'b1;

    localparam logic [2:0] STAT_ADDED       = 3'd0;
    localparam logic [2:0] STAT_POOL_FULL   = 3'd1;
    localparam logic [2:0] STAT_LEVELS_FULL = 3'd2;
    localparam logic [2:0] STAT_CANCELLED   = 3'd3;
    localparam logic [2:0] STAT_IGNORED     = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/order_book_price_level_fifo.sv
// ----------------------------------------------------------------------------
// order_book_price_level_fifo
// Order store with price levels, each level holding a doubly linked FIFO.
// ----------------------------------------------------------------------------
// An add takes the next pool slot (ids count up from 1 and are never reused),
// finds the level with the same price among the levels created so far or
// opens a new one, and appends the order at that level's tail. A cancel
// unlinks the order, moves the level head or tail past it and zeroes its
// quantity. Every item gives exactly one result. An add or a cancel that
// reaches the order memories steps through level compare or link read,
// memory update, result, and accept of the next item; its result register
// loads as it leaves the result step. Items rejected on a full pool, a
// full level table or an id out of range skip the memory update. The steps
// are set by the registered read of the order link memories and their
// single write port. A result that waits on the output only holds the last
// step; no new item is accepted until the result loads. Order memories need
// no clearing after reset: no entry is read before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module order_book_price_level_fifo #(
    parameter int POOL_SLOTS = 4096,
    parameter int MAX_LEVELS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  obplf_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output obplf_pkg::t_out_item o_out_item
);
    import obplf_pkg::*;

    localparam int AW   = $clog2(POOL_SLOTS);
    localparam int ID_W = $clog2(POOL_SLOTS + 1);
    localparam int LW   = $clog2(MAX_LEVELS);
    localparam int LCW  = $clog2(MAX_LEVELS + 1);

    // control and counters
    t_state           r_state, n_state;
    t_in_item         r_in;
    logic [ID_W-1:0]  r_slots_used;
    logic [LCW-1:0]   r_levels_used;
    logic             r_found;
    logic [LW-1:0]    r_lv;
    logic [2:0]       r_res_status, n_res_status;
    logic [ID_W-1:0]  r_res_id, n_res_id;
    logic             r_out_valid;
    t_out_item        r_out;

    // level table
    logic signed [31:0] r_level_price [MAX_LEVELS];
    logic [ID_W-1:0]    r_level_head  [MAX_LEVELS];
    logic [ID_W-1:0]    r_level_tail  [MAX_LEVELS];

    // order memories, slot id k lives at address k-1
    logic [ID_W-1:0] m_next [POOL_SLOTS];
    logic [ID_W-1:0] m_prev [POOL_SLOTS];
    logic [23:0]     m_qty  [POOL_SLOTS];
    logic [LW-1:0]   m_lvl  [POOL_SLOTS];
    logic [ID_W-1:0] r_rd_next;
    logic [ID_W-1:0] r_rd_prev;
    logic [23:0]     r_rd_qty;
    logic [LW-1:0]   r_rd_lvl;

    logic            w_in_acc;
    logic            w_pool_full;
    logic            w_lev_full;
    logic            w_hit_any;
    logic [LW-1:0]   w_hit_lv;
    logic [ID_W+12:0] w_oid_ext;
    logic [ID_W+12:0] w_slots_ext;
    logic [ID_W+12:0] w_oid_m1;
    logic            w_oid_bad;
    logic [AW-1:0]   w_cancel_addr;
    logic [ID_W-1:0] w_cancel_id;
    logic [ID_W-1:0] w_new_id;
    logic [AW-1:0]   w_new_addr;
    logic [LW-1:0]   w_lv_sel;
    logic [ID_W-1:0] w_head;
    logic [ID_W-1:0] w_tail;
    logic            w_append;
    logic [ID_W-1:0] w_tail_m1;
    logic [ID_W-1:0] w_p_m1;
    logic [ID_W-1:0] w_n_m1;
    logic            w_out_free;
    logic [ID_W+12:0] w_id_ext;
    logic [LCW+5:0]  w_lc_ext;

    logic            w_next_we;
    logic [AW-1:0]   w_next_addr;
    logic [ID_W-1:0] w_next_wdata;
    logic            w_prev_we;
    logic [AW-1:0]   w_prev_addr;
    logic [ID_W-1:0] w_prev_wdata;
    logic            w_qty_we;
    logic [AW-1:0]   w_qty_addr;
    logic [23:0]     w_qty_wdata;
    logic            w_lvl_we;
    logic            w_head_we;
    logic [ID_W-1:0] w_head_wdata;
    logic            w_tail_we;
    logic [ID_W-1:0] w_tail_wdata;
    logic            w_price_we;
    logic            w_slot_inc;
    logic            w_level_inc;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_pool_full = (r_slots_used == ID_W'(POOL_SLOTS));
    assign w_lev_full  = (r_levels_used == LCW'(MAX_LEVELS));

    // Level prices are unique, so at most one lane hits and an OR encodes it.
    always_comb begin
        w_hit_any = 1'b0;
        w_hit_lv  = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if ((r_levels_used > LCW'(i)) && (r_level_price[i] == r_in.price)) begin
                w_hit_any = 1'b1;
                w_hit_lv  = w_hit_lv | LW'(i);
            end
        end
    end

    assign w_oid_ext     = {{ID_W{1'b0}}, r_in.order_id};
    assign w_slots_ext   = {13'd0, r_slots_used};
    assign w_oid_bad     = (r_in.order_id == 13'd0) || (w_oid_ext > w_slots_ext);
    assign w_oid_m1      = w_oid_ext - 1'b1;
    assign w_cancel_addr = w_oid_m1[AW-1:0];
    assign w_cancel_id   = w_oid_ext[ID_W-1:0];
    assign w_new_id      = r_slots_used + 1'b1;
    assign w_new_addr    = r_slots_used[AW-1:0];

    assign w_lv_sel  = (r_state == S_CANCEL) ? r_rd_lvl : r_lv;
    assign w_head    = r_level_head[w_lv_sel];
    assign w_tail    = r_level_tail[w_lv_sel];
    assign w_append  = r_found && (w_head != '0);
    assign w_tail_m1 = w_tail - 1'b1;
    assign w_p_m1    = r_rd_prev - 1'b1;
    assign w_n_m1    = r_rd_next - 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_in.action == ACT_ADD) begin
                    if (w_pool_full || (!w_hit_any && w_lev_full)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_ADD;
                    end
                end else if (w_oid_bad) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_CANCEL;
                end
            end
            S_ADD:    n_state = S_EMIT;
            S_CANCEL: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // memory and table updates, result codes
    always_comb begin
        w_next_we    = 1'b0;
        w_next_addr  = w_new_addr;
        w_next_wdata = '0;
        w_prev_we    = 1'b0;
        w_prev_addr  = w_new_addr;
        w_prev_wdata = '0;
        w_qty_we     = 1'b0;
        w_qty_addr   = w_new_addr;
        w_qty_wdata  = r_in.quantity;
        w_lvl_we     = 1'b0;
        w_head_we    = 1'b0;
        w_head_wdata = w_new_id;
        w_tail_we    = 1'b0;
        w_tail_wdata = w_new_id;
        w_price_we   = 1'b0;
        w_slot_inc   = 1'b0;
        w_level_inc  = 1'b0;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        unique case (r_state)
            S_EXEC: begin
                n_res_id = '0;
                if (r_in.action == ACT_ADD) begin
                    if (w_pool_full) begin
                        n_res_status = STAT_POOL_FULL;
                    end else begin
                        // clear the forward link of the slot about to be taken
                        w_next_we = 1'b1;
                        if (!w_hit_any && w_lev_full) begin
                            n_res_status = STAT_LEVELS_FULL;
                        end
                    end
                end else begin
                    n_res_status = STAT_IGNORED;
                end
            end
            S_ADD: begin
                w_qty_we     = 1'b1;
                w_lvl_we     = 1'b1;
                w_prev_we    = 1'b1;
                w_prev_wdata = w_append ? w_tail : '0;
                w_tail_we    = 1'b1;
                w_head_we    = !w_append;
                w_price_we   = !r_found;
                w_level_inc  = !r_found;
                w_slot_inc   = 1'b1;
                if (w_append) begin
                    w_next_we    = 1'b1;
                    w_next_addr  = w_tail_m1[AW-1:0];
                    w_next_wdata = w_new_id;
                end
                n_res_status = STAT_ADDED;
                n_res_id     = w_new_id;
            end
            S_CANCEL: begin
                if (r_rd_qty == '0) begin
                    n_res_status = STAT_IGNORED;
                end else begin
                    n_res_status = STAT_CANCELLED;
                    w_qty_we     = 1'b1;
                    w_qty_addr   = w_cancel_addr;
                    w_qty_wdata  = '0;
                    if (r_rd_prev != '0) begin
                        w_next_we    = 1'b1;
                        w_next_addr  = w_p_m1[AW-1:0];
                        w_next_wdata = r_rd_next;
                    end else if (w_head == w_cancel_id) begin
                        w_head_we    = 1'b1;
                        w_head_wdata = r_rd_next;
                    end
                    if (r_rd_next != '0) begin
                        w_prev_we    = 1'b1;
                        w_prev_addr  = w_n_m1[AW-1:0];
                        w_prev_wdata = r_rd_prev;
                    end else if (w_tail == w_cancel_id) begin
                        w_tail_we    = 1'b1;
                        w_tail_wdata = r_rd_prev;
                    end
                end
            end
            S_IDLE, S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_slots_used  <= '0;
            r_levels_used <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_slot_inc) begin
                r_slots_used <= w_new_id;
            end
            if (w_level_inc) begin
                r_levels_used <= r_levels_used + 1'b1;
            end
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_id_ext = {13'd0, r_res_id};
    assign w_lc_ext = {6'd0, r_levels_used};

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_item;
        end
        if (r_state == S_EXEC) begin
            r_found <= w_hit_any;
            r_lv    <= w_hit_any ? w_hit_lv : r_levels_used[LW-1:0];
        end
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        if ((r_state == S_EMIT) && w_out_free) begin
            r_out.status      <= r_res_status;
            r_out.assigned_id <= w_id_ext[12:0];
            r_out.level_count <= w_lc_ext[5:0];
        end
    end

    // level table
    always_ff @(posedge i_clk) begin
        if (w_price_we) begin
            r_level_price[w_lv_sel] <= r_in.price;
        end
        if (w_head_we) begin
            r_level_head[w_lv_sel] <= w_head_wdata;
        end
        if (w_tail_we) begin
            r_level_tail[w_lv_sel] <= w_tail_wdata;
        end
    end

    // order memories, all read at the cancel address
    always_ff @(posedge i_clk) begin
        if (w_next_we) begin
            m_next[w_next_addr] <= w_next_wdata;
        end
        r_rd_next <= m_next[w_cancel_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_prev_we) begin
            m_prev[w_prev_addr] <= w_prev_wdata;
        end
        r_rd_prev <= m_prev[w_cancel_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_qty_we) begin
            m_qty[w_qty_addr] <= w_qty_wdata;
        end
        r_rd_qty <= m_qty[w_cancel_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_lvl_we) begin
            m_lvl[w_new_addr] <= r_lv;
        end
        r_rd_lvl <= m_lvl[w_cancel_addr];
    end

endmodule

`default_nettype wire
